[sv/mgic_pkg.sv]
// Package for the model graph input classifier.
// Holds parser phase and verdict codes, default sizes and the input name patterns.
// No dependencies.
`timescale 1ns / 1ps

package mgic_pkg;

    localparam int POS_BITS_DEF = 32;
    localparam int MAX_NAME_DEF = 1024;
    localparam int SKIP_W       = 32;
    localparam int PAT_NUM      = 4;

    typedef enum logic [2:0] {
        PH_KEY,
        PH_SKIPVAR,
        PH_SKIPLEN,
        PH_SKIPBYTES,
        PH_ENTERLEN,
        PH_NAME,
        PH_TAIL,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        OC_UNDECIDED,
        OC_DEFAULT,
        OC_FOUND
    } outcome_t;

    // Input name patterns as ASCII bytes, first character in the top byte:
    // channel cache, time cache, channel cache length, prompt index
    localparam logic [18*8-1:0] PAT0 = 144'h63616368655f6c6173745f6368616e6e656c;
    localparam logic [15*8-1:0] PAT1 = 120'h63616368655f6c6173745f74696d65;
    localparam logic [22*8-1:0] PAT2 = 176'h63616368655f6c6173745f6368616e6e656c5f6c656e;
    localparam logic [12*8-1:0] PAT3 = 96'h70726f6d70745f696e646578;

    // Length of each input name pattern
    function automatic logic [4:0] pat_len(input logic [1:0] k);
        logic [4:0] r;
        case (k)
            2'd0: r = 5'd18;
            2'd1: r = 5'd15;
            2'd2: r = 5'd22;
            default: r = 5'd12;
        endcase
        return r;
    endfunction

    // Character of a pattern; idx must be below the pattern length
    function automatic logic [7:0] pat_char(input logic [1:0] k, input logic [4:0] idx);
        logic [7:0] r;
        int         i;
        i = 0;
        r = 8'h00;
        case (k)
            2'd0: begin
                i = 17 - int'(idx);
                if (i >= 0) r = PAT0[i*8 +: 8];
            end
            2'd1: begin
                i = 14 - int'(idx);
                if (i >= 0) r = PAT1[i*8 +: 8];
            end
            2'd2: begin
                i = 21 - int'(idx);
                if (i >= 0) r = PAT2[i*8 +: 8];
            end
            default: begin
                i = 11 - int'(idx);
                if (i >= 0) r = PAT3[i*8 +: 8];
            end
        endcase
        return r;
    endfunction

endpackage

[sv/model_graph_input_classifier.sv]
// Top level of the model graph input classifier: streaming wire format parser.
// Depends on mgic_pkg for phase codes, verdict codes and name patterns.
//
// channel  direction  ports                                    moves
// cfg      in         cfg_valid/cfg_ready, cfg_data            file_size write
// s        in         s_valid/s_ready, s_data_byte, s_last_byte one file byte
// m        out        m_valid/m_ready, m_found_inputs, ...     verdict on last byte
//
// One byte is taken per cycle; the parse step for a byte is one registered pass
// through level exit, byte decode and a second level exit check.
// The verdict is loaded into the output register as the last byte is taken.
// A byte is taken while the output register is empty or being emptied.
// aresetn (synchronous, active low) clears the parser, file_size and m_valid.
`timescale 1ns / 1ps

module model_graph_input_classifier
    import mgic_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int MAX_NAME = MAX_NAME_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found_inputs,
    output logic        m_online_kind,
    output logic        m_uses_prompt
);

    localparam int EW   = (POS_BITS > 32) ? POS_BITS : 32;
    localparam int NL_W = $clog2(MAX_NAME + 1);

    typedef struct packed {
        phase_t              phase;
        logic [1:0]          nest;
        logic [63:0]         accum;
        logic [3:0]          shift;
        logic [SKIP_W-1:0]   skip;
        logic [31:0]         gend;
        logic [31:0]         iend;
        logic [NL_W-1:0]     nlen;
        logic [PAT_NUM-1:0]  nmatch;
        logic [4:0]          seen;
        outcome_t            outcome;
        logic [POS_BITS-1:0] pos;
    } parse_t;

    parse_t      st_reg, st_next;
    logic [31:0] fsize_reg;
    logic        m_valid_reg;
    logic        found_reg, online_reg, prompt_reg;

    function automatic parse_t clear_state();
        parse_t r;
        r.phase   = PH_KEY;
        r.nest    = 2'd0;
        r.accum   = '0;
        r.shift   = '0;
        r.skip    = '0;
        r.gend    = '0;
        r.iend    = '0;
        r.nlen    = '0;
        r.nmatch  = '1;
        r.seen    = '0;
        r.outcome = OC_UNDECIDED;
        r.pos     = '0;
        return r;
    endfunction

    function automatic logic [31:0] lvl_end(input parse_t s, input logic [31:0] fsz);
        logic [31:0] r;
        case (s.nest)
            2'd2: r = s.iend;
            2'd1: r = s.gend;
            default: r = fsz;
        endcase
        return r;
    endfunction

    // Leave a finished info and close out an exhausted level
    function automatic parse_t settle(input parse_t s, input logic [31:0] fsz);
        parse_t        r;
        logic [EW-1:0] p;
        r = s;
        p = EW'(s.pos);
        if (r.outcome == OC_UNDECIDED) begin
            if (r.nest == 2'd2 && r.phase == PH_TAIL && p >= EW'(r.iend)) begin
                r.nest  = 2'd1;
                r.phase = PH_KEY;
                r.accum = '0;
                r.shift = '0;
            end
            if (r.phase == PH_KEY && p >= EW'(lvl_end(r, fsz))) begin
                if (r.nest == 2'd1 && r.seen[0]) begin
                    r.outcome = OC_FOUND;
                end else begin
                    r.outcome = OC_DEFAULT;
                end
                r.phase = PH_DONE;
            end
        end
        return r;
    endfunction

    function automatic parse_t finish_name(input parse_t s);
        parse_t r;
        r = s;
        r.seen[0] = 1'b1;
        for (int k = 0; k < PAT_NUM; k++) begin
            if (s.nmatch[k] && s.nlen == NL_W'(pat_len(2'(k)))) r.seen[k+1] = 1'b1;
        end
        r.phase = PH_TAIL;
        return r;
    endfunction

    // Decode one byte in the current phase
    function automatic parse_t consume(input parse_t s, input logic [31:0] fsz,
                                       input logic [7:0] b);
        parse_t        r;
        logic [EW-1:0] le, p, room;
        logic [6:0]    sh;
        logic [63:0]   val;
        logic [SKIP_W-1:0] n;
        r   = s;
        le  = EW'(lvl_end(s, fsz));
        sh  = 7'(s.shift) * 7'd7;
        n   = '0;
        if (EW'(s.pos) >= le) begin
            r.outcome = OC_DEFAULT;
            r.phase   = PH_DONE;
            return r;
        end
        if (s.pos != '1) r.pos = s.pos + 1'b1;
        p    = EW'(r.pos);
        room = le - p;
        case (s.phase)
            PH_KEY, PH_SKIPVAR, PH_SKIPLEN, PH_ENTERLEN: begin
                r.accum = s.accum | ({57'b0, b[6:0]} << sh);
                val     = r.accum;
                if (b[7]) begin
                    r.shift = s.shift + 1'b1;
                    if (r.shift >= 4'd10) begin
                        r.outcome = OC_DEFAULT;
                        r.phase   = PH_DONE;
                    end
                end else if (s.phase == PH_KEY) begin
                    r.accum = '0;
                    r.shift = '0;
                    if (val < 64'd8 || val[63:32] != '0) begin
                        r.outcome = OC_DEFAULT;
                        r.phase   = PH_DONE;
                    end else if (val[2:0] == 3'd2 &&
                                 ((s.nest == 2'd0 && val[31:3] == 29'd7) ||
                                  (s.nest == 2'd1 && val[31:3] == 29'd11) ||
                                  (s.nest == 2'd2 && val[31:3] == 29'd1))) begin
                        r.phase = PH_ENTERLEN;
                    end else begin
                        case (val[2:0])
                            3'd0: r.phase = PH_SKIPVAR;
                            3'd2: r.phase = PH_SKIPLEN;
                            3'd1: begin
                                if (room < EW'(8)) begin
                                    r.outcome = OC_DEFAULT;
                                    r.phase   = PH_DONE;
                                end else begin
                                    r.skip  = SKIP_W'(8);
                                    r.phase = PH_SKIPBYTES;
                                end
                            end
                            3'd5: begin
                                if (room < EW'(4)) begin
                                    r.outcome = OC_DEFAULT;
                                    r.phase   = PH_DONE;
                                end else begin
                                    r.skip  = SKIP_W'(4);
                                    r.phase = PH_SKIPBYTES;
                                end
                            end
                            default: begin
                                r.outcome = OC_DEFAULT;
                                r.phase   = PH_DONE;
                            end
                        endcase
                    end
                end else if (s.phase == PH_SKIPVAR) begin
                    r.accum = '0;
                    r.shift = '0;
                    r.phase = PH_KEY;
                end else if (s.phase == PH_SKIPLEN) begin
                    r.accum = '0;
                    r.shift = '0;
                    if (val > 64'(room)) begin
                        r.outcome = OC_DEFAULT;
                        r.phase   = PH_DONE;
                    end else begin
                        n       = SKIP_W'(val);
                        r.skip  = n;
                        r.phase = (n == '0) ? PH_KEY : PH_SKIPBYTES;
                    end
                end else begin
                    // length of an entered field
                    if (val > 64'(room)) begin
                        r.outcome = OC_DEFAULT;
                        r.phase   = PH_DONE;
                    end else if (s.nest == 2'd0) begin
                        r.gend  = 32'(p + EW'(val[31:0]));
                        r.nest  = 2'd1;
                        r.accum = '0;
                        r.shift = '0;
                        r.phase = PH_KEY;
                    end else if (s.nest == 2'd1) begin
                        r.iend  = 32'(p + EW'(val[31:0]));
                        r.nest  = 2'd2;
                        r.accum = '0;
                        r.shift = '0;
                        r.phase = PH_KEY;
                    end else if (val > 64'(MAX_NAME)) begin
                        r.outcome = OC_DEFAULT;
                        r.phase   = PH_DONE;
                    end else begin
                        r.skip   = SKIP_W'(val);
                        r.nlen   = '0;
                        r.nmatch = '1;
                        r.phase  = PH_NAME;
                        if (val == '0) r = finish_name(r);
                    end
                end
            end
            PH_SKIPBYTES: begin
                if (s.skip != '0) r.skip = s.skip - 1'b1;
                if (r.skip == '0) begin
                    r.accum = '0;
                    r.shift = '0;
                    r.phase = PH_KEY;
                end
            end
            PH_NAME: begin
                for (int k = 0; k < PAT_NUM; k++) begin
                    if (s.nlen >= NL_W'(pat_len(2'(k)))) begin
                        r.nmatch[k] = 1'b0;
                    end else if (pat_char(2'(k), 5'(s.nlen)) != b) begin
                        r.nmatch[k] = 1'b0;
                    end
                end
                r.nlen = s.nlen + 1'b1;
                if (s.skip != '0) r.skip = s.skip - 1'b1;
                if (r.skip == '0) r = finish_name(r);
            end
            default: ;
        endcase
        return r;
    endfunction

    parse_t s_pre, s_mid, s_post;
    logic   found_c, online_c, prompt_c;
    logic   s_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = ~m_valid_reg | m_ready;
    assign s_fire    = s_valid & s_ready;

    // Parse step for the offered byte
    always_comb begin
        s_pre  = settle(st_reg, fsize_reg);
        s_mid  = s_pre;
        s_post = s_pre;
        if (st_reg.outcome == OC_UNDECIDED) begin
            if (s_pre.outcome == OC_UNDECIDED) s_mid = consume(s_pre, fsize_reg, s_data_byte);
            s_post = settle(s_mid, fsize_reg);
        end else begin
            s_post = st_reg;
            if (st_reg.pos != '1) s_post.pos = st_reg.pos + 1'b1;
        end
        found_c  = (s_post.outcome == OC_FOUND);
        online_c = found_c && (s_post.seen[3:1] == 3'b111);
        prompt_c = online_c && s_post.seen[4];
        st_next  = st_reg;
        if (s_fire) st_next = s_last_byte ? clear_state() : s_post;
    end

    // Hold parser state and file size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= clear_state();
            fsize_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (cfg_valid) fsize_reg <= cfg_data;
        end
    end

    // Output register: load on last byte transfer, drop on result transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && s_last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_last_byte) begin
            found_reg  <= found_c;
            online_reg <= online_c;
            prompt_reg <= prompt_c;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found_inputs = found_reg;
    assign m_online_kind  = online_reg;
    assign m_uses_prompt  = prompt_reg;

endmodule
